// ===== sv/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, constants and the CRC7 byte step for the SD SPI sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package sdspi_pkg;

  localparam int BLOCK_BYTES   = 512;
  localparam int ADDRESS_SHIFT = 9;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_XCHG  = 2'd2;
  localparam logic [1:0] OP_ABORT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_RETRY_COMMAND = 3'd0;
  localparam logic [2:0] CFG_RETRY_REPLY   = 3'd1;
  localparam logic [2:0] CFG_RETRY_STORE   = 3'd2;
  localparam logic [2:0] CFG_DELAY_INIT    = 3'd3;
  localparam logic [2:0] CFG_DELAY_RW      = 3'd4;
  localparam logic [2:0] CFG_DELAY_STORE   = 3'd5;
  localparam logic [2:0] CFG_CRC_POLY      = 3'd6;

  // bytes on the wire
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] TOKEN_START   = 8'hFE;
  localparam logic [7:0] CMD_PREFIX    = 8'h40;
  localparam logic [7:0] RESP_MASK     = 8'h1F;
  localparam logic [7:0] RESP_ACCEPTED = 8'h05;
  localparam logic [7:0] R1_IDLE       = 8'h01;
  localparam logic [7:0] R1_READY      = 8'h00;

  // commands
  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD1  = 6'd1;
  localparam logic [5:0] CMD13 = 6'd13;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [22:0] block_number;
    logic [9:0]  length;
    logic [7:0]  data_byte;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        chip_select_n;
    logic [15:0] delay_units;
    logic        data_request;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        done_res;
    logic        status;
  } out_item_t;

  // request class decided at the front
  typedef struct packed {
    logic start;
    logic xchg;
    logic abort;
  } cls_t;

  typedef struct packed {
    logic [7:0] retry_command;
    logic [7:0] retry_reply;
    logic [7:0] retry_store;
    logic [15:0] delay_init;
    logic [15:0] delay_rw;
    logic [15:0] delay_store;
    logic [7:0] crc_poly;
  } cfg_t;

  function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b,
                                          logic [7:0] poly);
    logic [7:0] c;
    logic hi;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      hi = c[7];
      c  = {c[6:0], b[7-i]};
      if (hi) c = c ^ poly;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sdspi_front.sv =====
// ----------------------------------------------------------------------------
// sdspi_front
// Accept requests, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sdspi_pkg::in_item_t in_item,
  output logic                   q_valid,
  output sdspi_pkg::in_item_t    q_item,
  output sdspi_pkg::cls_t        q_cls,
  input  wire logic              q_pop
);

  sdspi_pkg::in_item_t item_r [2];
  sdspi_pkg::cls_t     cls_r  [2];
  logic                wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push, pop;
  sdspi_pkg::cls_t     cls_in;

  always_comb begin
    cls_in.start = (in_item.opcode == sdspi_pkg::OP_READ) ||
                   (in_item.opcode == sdspi_pkg::OP_WRITE);
    cls_in.xchg  = (in_item.opcode == sdspi_pkg::OP_XCHG);
    cls_in.abort = (in_item.opcode == sdspi_pkg::OP_ABORT);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = item_r[rp_r];
  assign q_cls    = cls_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wp_r] <= in_item;
      cls_r[wp_r]  <= cls_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sdspi_crc.sv =====
// ----------------------------------------------------------------------------
// sdspi_crc
// Fold the command byte and the four argument bytes into CRC7, one byte a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_crc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [5:0]  cmd,
  input  wire logic [31:0] arg,
  input  wire logic [7:0]  poly,
  output logic [7:0]       crc
);

  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] arg_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  arg_byte;

  always_comb begin
    case (cnt_r)
      3'd1:    arg_byte = arg_r[31:24];
      3'd2:    arg_byte = arg_r[23:16];
      3'd3:    arg_byte = arg_r[15:8];
      default: arg_byte = arg_r[7:0];
    endcase
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (start) begin
      crc_nxt = sdspi_pkg::crc_step(8'h00, sdspi_pkg::CMD_PREFIX | {2'b00, cmd}, poly);
      cnt_nxt = 3'd1;
    end else if (cnt_r != 3'd0 && cnt_r != 3'd5) begin
      crc_nxt = sdspi_pkg::crc_step(crc_r, arg_byte, poly);
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 3'd0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (start) arg_r <= arg;
  end

  assign crc = crc_r;

endmodule
`default_nettype wire

// ===== sv/sdspi_outq.sv =====
// ----------------------------------------------------------------------------
// sdspi_outq
// Two-entry result queue; keeps the sequencer running while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sdspi_pkg::out_item_t push_item,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sdspi_pkg::out_item_t      out_item
);

  sdspi_pkg::out_item_t item_r [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = item_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) item_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

// ===== sv/sdspi_seq.sv =====
// ----------------------------------------------------------------------------
// sdspi_seq
// Transfer sequencer: one request in, one result out, per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire sdspi_pkg::in_item_t q_item,
  input  wire sdspi_pkg::cls_t     q_cls,
  output logic                     q_pop,
  input  wire sdspi_pkg::cfg_t     cfg,
  output logic                     res_push,
  output sdspi_pkg::out_item_t     res_item,
  input  wire logic                res_full
);

  localparam logic [3:0] P_IDLE     = 4'd0;
  localparam logic [3:0] P_FRAME    = 4'd1;
  localparam logic [3:0] P_REPLY    = 4'd2;
  localparam logic [3:0] P_TAIL     = 4'd3;
  localparam logic [3:0] P_FLUSH10  = 4'd4;
  localparam logic [3:0] P_FLUSH2   = 4'd5;
  localparam logic [3:0] P_RTOKEN   = 4'd6;
  localparam logic [3:0] P_RDATA    = 4'd7;
  localparam logic [3:0] P_WTOKEN   = 4'd8;
  localparam logic [3:0] P_WAITDATA = 4'd9;
  localparam logic [3:0] P_WDATA    = 4'd10;
  localparam logic [3:0] P_WRESP    = 4'd11;
  localparam logic [3:0] P_WBUSY    = 4'd12;
  localparam logic [3:0] P_WTAIL    = 4'd13;

  localparam logic [9:0] BLK    = 10'(sdspi_pkg::BLOCK_BYTES);
  localparam logic [9:0] BLK_P2 = 10'(sdspi_pkg::BLOCK_BYTES + 2);
  localparam logic [9:0] BLK_P3 = 10'(sdspi_pkg::BLOCK_BYTES + 3);

  logic [3:0]  phase_r, phase_nxt;
  logic        wr_r, wr_nxt;
  logic [22:0] blk_r, blk_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [7:0]  resp_r, resp_nxt;
  logic [5:0]  cmd_r, cmd_nxt;

  logic        st_go;
  logic [5:0]  st_cmd;
  logic [15:0] st_pre;
  logic [31:0] st_arg;
  logic [31:0] blk_arg;
  logic [7:0]  crc_val;
  logic [7:0]  crc_last;
  logic [7:0]  fbyte;
  logic [15:0] poll_dly;
  logic [7:0]  rx;
  sdspi_pkg::out_item_t r;

  assign q_pop    = q_valid && !res_full;
  assign res_push = q_pop;
  assign res_item = r;
  assign rx       = q_item.rx_byte;
  assign blk_arg  = {9'b0, blk_r} << sdspi_pkg::ADDRESS_SHIFT;

  sdspi_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_go && q_pop),
    .cmd   (st_cmd),
    .arg   (st_arg),
    .poly  (cfg.crc_poly),
    .crc   (crc_val)
  );

  assign crc_last = sdspi_pkg::crc_step(crc_val, sdspi_pkg::BYTE_ZERO, cfg.crc_poly) | 8'h01;

  always_comb begin
    case (cmd_r)
      sdspi_pkg::CMD0:                  poll_dly = cfg.delay_init;
      sdspi_pkg::CMD17, sdspi_pkg::CMD24: poll_dly = cfg.delay_rw;
      default:                          poll_dly = 16'd1;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r; wr_nxt = wr_r; blk_nxt = blk_r; len_nxt = len_r;
    bc_nxt = bc_r; retry_nxt = retry_r; poll_nxt = poll_r; resp_nxt = resp_r;
    cmd_nxt = cmd_r;
    st_go = 1'b0; st_cmd = cmd_r; st_pre = 16'd0;
    fbyte = 8'h00;
    r = '0;
    r.chip_select_n = (phase_r == P_IDLE) || (phase_r == P_FLUSH10) ||
                      (phase_r == P_FLUSH2);

    if (q_cls.start) begin
      if (phase_r == P_IDLE) begin
        wr_nxt  = q_item.opcode[0];
        blk_nxt = q_item.block_number;
        len_nxt = q_item.length;
        st_go   = 1'b1;
        st_cmd  = sdspi_pkg::CMD13;
      end
    end else if (q_cls.abort) begin
      if (phase_r != P_IDLE) begin
        phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
      end
    end else if (q_cls.xchg) begin
      case (phase_r)
        P_FRAME: begin
          bc_nxt = bc_r + 10'd1;
          case (bc_nxt[2:0])
            3'd1:    fbyte = blk_arg[31:24] & {8{cmd_r == sdspi_pkg::CMD17 ||
                                                  cmd_r == sdspi_pkg::CMD24}};
            3'd2:    fbyte = blk_arg[23:16] & {8{cmd_r == sdspi_pkg::CMD17 ||
                                                  cmd_r == sdspi_pkg::CMD24}};
            3'd3:    fbyte = blk_arg[15:8] & {8{cmd_r == sdspi_pkg::CMD17 ||
                                                 cmd_r == sdspi_pkg::CMD24}};
            3'd4:    fbyte = blk_arg[7:0] & {8{cmd_r == sdspi_pkg::CMD17 ||
                                                cmd_r == sdspi_pkg::CMD24}};
            default: fbyte = crc_last;
          endcase
          r.tx_valid = 1'b1; r.chip_select_n = 1'b0;
          if (bc_nxt < 10'd6) begin
            r.tx_byte = fbyte;
          end else begin
            poll_nxt  = 8'd0;
            phase_nxt = (cfg.retry_reply == 8'd0) ? P_TAIL : P_REPLY;
            r.tx_byte = sdspi_pkg::BYTE_IDLE;
          end
        end
        P_REPLY: begin
          r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
          if (rx != sdspi_pkg::BYTE_IDLE) begin
            resp_nxt = rx; phase_nxt = P_TAIL;
          end else begin
            poll_nxt = poll_r + 8'd1;
            if (poll_nxt >= cfg.retry_reply) phase_nxt = P_TAIL;
            r.delay_units = poll_dly;
          end
        end
        P_TAIL: begin
          if (cmd_r == sdspi_pkg::CMD13 && resp_r == sdspi_pkg::BYTE_IDLE) begin
            phase_nxt = P_FLUSH10; bc_nxt = 10'd0;
            r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b1;
          end else if (cmd_r == sdspi_pkg::CMD0 && resp_r == sdspi_pkg::R1_IDLE) begin
            phase_nxt = P_FLUSH2; bc_nxt = 10'd0;
            r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b1;
          end else if (cmd_r == sdspi_pkg::CMD13 ||
                       (cmd_r == sdspi_pkg::CMD1 && resp_r == sdspi_pkg::R1_READY)) begin
            // init finished: check length and command retry limit, then issue the data command
            retry_nxt = 8'd0;
            if (len_r > BLK || cfg.retry_command == 8'd0) begin
              phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
            end else begin
              st_go  = 1'b1;
              st_cmd = wr_r ? sdspi_pkg::CMD24 : sdspi_pkg::CMD17;
            end
          end else if (cmd_r == sdspi_pkg::CMD17 && resp_r == sdspi_pkg::R1_READY) begin
            poll_nxt = 8'd0;
            if (cfg.retry_reply == 8'd0) begin
              phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
            end else begin
              phase_nxt = P_RTOKEN;
              r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
            end
          end else if (cmd_r != sdspi_pkg::CMD0 && cmd_r != sdspi_pkg::CMD1 &&
                       resp_r == sdspi_pkg::R1_READY) begin
            phase_nxt = P_WTOKEN;
            r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::TOKEN_START; r.chip_select_n = 1'b0;
          end else begin
            // wrong or missing reply: retry the same command until the command retry limit
            retry_nxt = retry_r + 8'd1;
            if (retry_nxt >= cfg.retry_command) begin
              phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
            end else begin
              st_go = 1'b1; st_pre = 16'd1;
            end
          end
        end
        P_FLUSH10, P_FLUSH2: begin
          bc_nxt = bc_r + 10'd1;
          if (bc_nxt < ((phase_r == P_FLUSH10) ? 10'd10 : 10'd2)) begin
            r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b1;
          end else begin
            retry_nxt = 8'd0;
            if (cfg.retry_command == 8'd0) begin
              phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
            end else begin
              st_go  = 1'b1;
              st_cmd = (phase_r == P_FLUSH10) ? sdspi_pkg::CMD0 : sdspi_pkg::CMD1;
            end
          end
        end
        P_RTOKEN, P_WRESP: begin
          if ((phase_r == P_RTOKEN && rx == sdspi_pkg::TOKEN_START) ||
              (phase_r == P_WRESP &&
               (rx & sdspi_pkg::RESP_MASK) == sdspi_pkg::RESP_ACCEPTED)) begin
            if (phase_r == P_RTOKEN) begin
              phase_nxt = P_RDATA; bc_nxt = 10'd0;
              r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
            end else begin
              poll_nxt = 8'd0;
              if (cfg.retry_store == 8'd0) begin
                phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1;
                r.status = 1'b1;
              end else begin
                phase_nxt = P_WBUSY;
                r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
              end
            end
          end else begin
            poll_nxt = poll_r + 8'd1;
            if (poll_nxt >= cfg.retry_reply) begin
              phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
            end else begin
              r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
              r.delay_units = 16'd1;
            end
          end
        end
        P_RDATA: begin
          if (bc_r < len_r) begin
            r.read_valid = 1'b1; r.read_byte = rx;
          end
          bc_nxt = bc_r + 10'd1;
          if (bc_nxt < BLK_P3) begin
            r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
          end else begin
            phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1;
          end
        end
        P_WTOKEN, P_WDATA: begin
          bc_nxt = (phase_r == P_WTOKEN) ? 10'd0 : bc_r + 10'd1;
          if (bc_nxt < len_r) begin
            phase_nxt = P_WAITDATA; r.chip_select_n = 1'b0; r.data_request = 1'b1;
          end else if (bc_nxt < BLK_P2) begin
            phase_nxt = P_WDATA;
            r.tx_valid = 1'b1; r.chip_select_n = 1'b0;
            r.tx_byte = (bc_nxt < BLK) ? sdspi_pkg::BYTE_ZERO : sdspi_pkg::BYTE_IDLE;
          end else begin
            poll_nxt = 8'd0;
            if (cfg.retry_reply == 8'd0) begin
              phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1; r.status = 1'b1;
            end else begin
              phase_nxt = P_WRESP;
              r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
            end
          end
        end
        P_WAITDATA: begin
          phase_nxt = P_WDATA;
          r.tx_valid = 1'b1; r.tx_byte = q_item.data_byte; r.chip_select_n = 1'b0;
        end
        P_WBUSY: begin
          r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; r.chip_select_n = 1'b0;
          if (rx != sdspi_pkg::BYTE_ZERO) begin
            phase_nxt = P_WTAIL;
          end else begin
            poll_nxt = poll_r + 8'd1;
            if (poll_nxt >= cfg.retry_store) begin
              phase_nxt = P_IDLE; r = '0; r.chip_select_n = 1'b1; r.done_res = 1'b1;
              r.status = 1'b1;
            end else begin
              r.delay_units = cfg.delay_store;
            end
          end
        end
        P_WTAIL: begin
          phase_nxt = P_IDLE; r.chip_select_n = 1'b1; r.done_res = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // open a command frame
    if (st_go) begin
      cmd_nxt   = st_cmd;
      bc_nxt    = 10'd0;
      resp_nxt  = sdspi_pkg::BYTE_IDLE;
      phase_nxt = P_FRAME;
      r.tx_valid = 1'b1;
      r.tx_byte  = sdspi_pkg::CMD_PREFIX | {2'b00, st_cmd};
      r.chip_select_n = 1'b0;
      r.delay_units   = st_pre;
    end
  end

  assign st_arg = (st_cmd == sdspi_pkg::CMD17 || st_cmd == sdspi_pkg::CMD24) ?
                  ({9'b0, blk_nxt} << sdspi_pkg::ADDRESS_SHIFT) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; wr_r <= 1'b0; blk_r <= '0; len_r <= '0; bc_r <= '0;
      retry_r <= '0; poll_r <= '0; resp_r <= sdspi_pkg::BYTE_IDLE; cmd_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt; wr_r <= wr_nxt; blk_r <= blk_nxt; len_r <= len_nxt;
      bc_r <= bc_nxt; retry_r <= retry_nxt; poll_r <= poll_nxt; resp_r <= resp_nxt;
      cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sd_spi_block_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_sequencer
// SD card single-block read/write sequencer in SPI mode, one byte exchange
// per request.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: requests (start read, start write, exchange result, abort). Each
//    request yields exactly one result on out_*: the next byte to exchange,
//    chip select level, idle delay, data request, read data and done/status.
//  - cfg_*: register writes (retry limits, poll delays, CRC polynomial); write only
//    while no transfer is running. cfg_ready is always high.
//  - Path: a request is registered in the input queue, its result in the output
//    queue. Throughput: one request per cycle while the output queue has room,
//    set by the single state update in the sequencer; the CRC7 of a command is
//    folded one byte a cycle while the first frame bytes go out.
//  - Input and output each pass through a two-entry queue, so a stalled
//    receiver holds the sequencer while in_ready stays high until both
//    queues fill.
//  - Reset (synchronous, rst_n low) empties both queues, returns to idle with
//    the card released and reloads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module sd_spi_block_transfer_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sdspi_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sdspi_pkg::out_item_t      out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic                 q_valid, q_pop, res_push, res_full;
  sdspi_pkg::in_item_t  q_item;
  sdspi_pkg::cls_t      q_cls;
  sdspi_pkg::out_item_t res_item;
  sdspi_pkg::cfg_t      cfg_r, cfg_nxt;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        sdspi_pkg::CFG_RETRY_COMMAND: cfg_nxt.retry_command = cfg_data[7:0];
        sdspi_pkg::CFG_RETRY_REPLY:   cfg_nxt.retry_reply   = cfg_data[7:0];
        sdspi_pkg::CFG_RETRY_STORE:   cfg_nxt.retry_store   = cfg_data[7:0];
        sdspi_pkg::CFG_DELAY_INIT:    cfg_nxt.delay_init    = cfg_data;
        sdspi_pkg::CFG_DELAY_RW:      cfg_nxt.delay_rw      = cfg_data;
        sdspi_pkg::CFG_DELAY_STORE:   cfg_nxt.delay_store   = cfg_data;
        sdspi_pkg::CFG_CRC_POLY:      cfg_nxt.crc_poly      = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_command <= 8'd5;
      cfg_r.retry_reply   <= 8'd5;
      cfg_r.retry_store   <= 8'd100;
      cfg_r.delay_init    <= 16'd1;
      cfg_r.delay_rw      <= 16'd1;
      cfg_r.delay_store   <= 16'd150;
      cfg_r.crc_poly      <= 8'h12;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify requests
  sdspi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_cls    (q_cls),
    .q_pop    (q_pop)
  );

  // back: sequence the transfer, one request per cycle while the result queue has room
  sdspi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_cls    (q_cls),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .res_push (res_push),
    .res_item (res_item),
    .res_full (res_full)
  );

  // results wait here for the receiver
  sdspi_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .full      (res_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
